FILE: design/trbd_pkg.sv
// Shared types and function codes for the transmit ring burst drain block.
`default_nettype none

package trbd_pkg;

	// Function codes carried in an input transaction
	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_TXDONE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// Input transaction payload
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic        last_of_write;
		logic        link_up;
		logic        endpoint_ready;
		logic [10:0] read_index;
	} in_item_t;

	// Result transaction payload
	typedef struct packed {
		logic        byte_accepted;
		logic        send_valid;
		logic [10:0] send_start;
		logic [6:0]  send_length;
		logic [7:0]  read_data;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} trbd_cmd_t;

endpackage

`default_nettype wire

FILE: design/trbd_ctrl.sv
// Controller state machine: sequences capture, execute and result hand-off.
`default_nettype none

module trbd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output trbd_pkg::trbd_cmd_t    cmd
);
	import trbd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_SEND;
			end
			ST_SEND: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Handshakes and datapath commands
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_SEND);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.exec    = (state_q == ST_EXEC);

	// One transaction in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (cmd.exec && !in_ready && !out_valid))
		else $error("transaction accepted while another was in flight");

	a_result_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("execute step not followed by a result");

	// A stalled result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn while the receiver stalled");

endmodule

`default_nettype wire

FILE: design/trbd_dpath.sv
// Datapath: ring memory, pointers, busy flag, pump arithmetic and result register.
`default_nettype none

module trbd_dpath #(
	parameter int RING_DEPTH = 2048,
	parameter int MAX_CHUNK  = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire trbd_pkg::trbd_cmd_t  cmd,
	input  wire trbd_pkg::in_item_t   in_data,
	output trbd_pkg::out_item_t       out_data
);
	import trbd_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int SW = PW + 1;

	logic [7:0]    mem [RING_DEPTH];

	in_item_t      item_q;
	logic [7:0]    rd_q;
	logic          range_q;
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic          busy_q;
	out_item_t     res_q;

	logic          is_wr;
	logic          is_txd;
	logic          is_rd;
	logic [PW-1:0] wp_inc;
	logic          store;
	logic [PW-1:0] wp_new;
	logic          run;
	logic          busy_eff;
	logic          issue;
	logic [SW-1:0] span_full;
	logic [SW-1:0] span;
	logic [SW-1:0] rp_sum;
	logic [PW-1:0] rp_new;
	out_item_t     res_d;

	// Capture the transaction and read the ring at the requested index
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q  <= in_data;
			rd_q    <= mem[PW'(in_data.read_index)];
			range_q <= (32'(in_data.read_index) < 32'(RING_DEPTH));
		end
	end

	// Ring write port
	always_ff @(posedge clk) begin
		if (cmd.exec && store) begin
			mem[wp_q] <= item_q.data_byte;
		end
	end

	// Decode
	assign is_wr  = (item_q.func == FUNC_WRITE);
	assign is_txd = (item_q.func == FUNC_TXDONE);
	assign is_rd  = (item_q.func == FUNC_READ);

	// Enqueue: one slot always stays empty
	assign wp_inc = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign store  = is_wr && item_q.link_up && (wp_inc != rp_q);
	assign wp_new = store ? wp_inc : wp_q;

	// Pump decision, seen after this transaction's enqueue
	assign run      = (is_wr && item_q.link_up && item_q.last_of_write) || is_txd;
	assign busy_eff = is_txd ? 1'b0 : busy_q;
	assign issue    = run && !busy_eff && (wp_new != rp_q) && item_q.link_up
		&& item_q.endpoint_ready;

	// Chunk length: up to the head or the wrap point, capped
	always_comb begin
		if (wp_new > rp_q) begin
			span_full = {1'b0, wp_new} - {1'b0, rp_q};
		end else begin
			span_full = SW'(RING_DEPTH) - {1'b0, rp_q};
		end
		if (32'(span_full) > 32'(MAX_CHUNK)) begin
			span = SW'(MAX_CHUNK);
		end else begin
			span = span_full;
		end
	end

	// Tail advance; the chunk never passes the wrap point
	assign rp_sum = {1'b0, rp_q} + span;
	assign rp_new = (rp_sum >= SW'(RING_DEPTH)) ? '0 : rp_sum[PW-1:0];

	// Result fields
	always_comb begin
		res_d.byte_accepted = store;
		res_d.send_valid    = issue;
		res_d.send_start    = issue ? 11'(rp_q) : '0;
		res_d.send_length   = issue ? 7'(span) : '0;
		res_d.read_data     = (is_rd && range_q) ? rd_q : '0;
	end

	// Pointer and busy state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			busy_q <= 1'b0;
		end else if (cmd.exec) begin
			wp_q   <= wp_new;
			rp_q   <= issue ? rp_new : rp_q;
			busy_q <= issue ? 1'b1 : busy_eff;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign out_data = res_q;

	a_issue_moves_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && issue) |=> (rp_q != $past(rp_q) && busy_q))
		else $error("issued chunk did not advance the tail or set busy");

	a_store_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && store) |=> (wp_q != $past(wp_q)))
		else $error("stored byte did not advance the head");

	a_read_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_rd) |=> (!res_q.send_valid && !res_q.byte_accepted
			&& wp_q == $past(wp_q) && rp_q == $past(rp_q)))
		else $error("read transaction changed ring state");

endmodule

`default_nettype wire

FILE: design/tx_ring_burst_drain_unit.sv
// Top level of the byte transmit ring with burst drain to an endpoint.
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per item:
//   a byte write, a transmit-complete notice or a ring read. The output
//   channel (out_valid/out_ready/out_data) returns exactly one result per item.
//   A byte write stores into the ring unless the link is down or the ring is
//   full; the last byte of a write and every transmit-complete run the pump,
//   which may issue one chunk (start, length) and then stays busy until the
//   next transmit-complete.
// Timing:
//   An item is accepted, executed in the following cycle, and its result is
//   presented from the cycle after that. The next item is taken in the cycle
//   after the result is taken, so the block does not take a new item until the
//   result of the last one is taken; the controller holds one item in flight and
//   the ring memory is read on capture and written on execute.
// Reset and stalls:
//   arst_n clears the pointers, the busy flag and the controller at once; the
//   ring contents are not cleared, so no clearing pass is needed. While the
//   receiver holds out_ready low the result stays on out_data and in_ready
//   stays low.
`default_nettype none

module tx_ring_burst_drain_unit #(
	parameter int RING_DEPTH = 2048,
	parameter int MAX_CHUNK  = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire trbd_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output trbd_pkg::out_item_t      out_data
);
	import trbd_pkg::*;

	trbd_cmd_t cmd;

	// Sequencing
	trbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Ring, pointers and pump
	trbd_dpath #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_CHUNK  (MAX_CHUNK)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
